// ----- hw/rtl/serial_line_editor_tokenizer_core_macros.svh -----
// assertion macros shared by the line editor rtl
// no dependencies; each user must have clk and rst_n in scope
`ifndef SERIAL_LINE_EDITOR_TOKENIZER_CORE_MACROS_SVH
`define SERIAL_LINE_EDITOR_TOKENIZER_CORE_MACROS_SVH

// property that must hold at every clock edge out of reset
`define SLET_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked in the cycle after the antecedent
`define SLET_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// implication checked in the same cycle
`define SLET_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/slet_pkg.sv -----
// shared types, character codes and defaults for the line editor / tokenizer
// no dependencies
package slet_pkg;

    localparam int LINE_CHARS_DEF = 32;
    localparam int MAX_TOKENS_DEF = 8;
    localparam int STORE_BITS     = 7;

    // terminal character codes
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_DEL = 8'd127;
    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_SP  = 8'd32;
    localparam logic [7:0] CH_TAB = 8'd9;

    // result kinds
    localparam logic [1:0] KIND_ECHO  = 2'd0;
    localparam logic [1:0] KIND_TOKEN = 2'd1;
    localparam logic [1:0] KIND_SUM   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ECHO,
        S_FETCH,
        S_DATA,
        S_LAST,
        S_SUM
    } state_t;

    typedef enum logic [1:0] {
        OP_CHAR,
        OP_ERASE,
        OP_EOL
    } op_t;

    function automatic logic is_sep(input logic [STORE_BITS-1:0] c);
        return (c == CH_SP[STORE_BITS-1:0]) || (c == CH_TAB[STORE_BITS-1:0]);
    endfunction

endpackage

// ----- hw/rtl/serial_line_editor_tokenizer_core.sv -----
// serial line editor with whitespace tokenizer, one terminal byte per input transfer
// the first result of a byte is loaded from the echo state into the output register; dropped bytes give none
// a line end holds the input through two echo slots, one store read and one decide step per
// stored character up to the token limit, a final token character slot if a token ends the line, a summary slot
// throughput: one byte at a time, in_ready only while idle; output stalls add cycles
// reset (async, active low) empties the line and the output register; store is not cleared
module serial_line_editor_tokenizer_core
    import slet_pkg::*;
#(
    parameter int LINE_CHARS = LINE_CHARS_DEF,
    parameter int MAX_TOKENS = MAX_TOKENS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] byte_value,
    output logic [2:0] token_index,
    output logic       token_end,
    output logic [3:0] token_count,
    output logic [5:0] line_length,
    output logic       last
);

    `include "serial_line_editor_tokenizer_core_macros.svh"

    localparam int CW = $clog2(LINE_CHARS + 1);
    localparam int AW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
    localparam int TW = $clog2(MAX_TOKENS + 1);

    // sequencer and datapath registers
    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [1:0]            step_reg, step_next;
    logic [7:0]            char_reg, char_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         ptr_reg, ptr_next;
    logic [TW-1:0]         tok_reg, tok_next;
    logic                  have_cur_reg, have_cur_next;
    logic [STORE_BITS-1:0] cur_reg, cur_next;

    // output register
    logic       out_valid_reg;
    logic [1:0] kind_reg;
    logic [7:0] byte_reg;
    logic [2:0] index_reg;
    logic       end_reg;
    logic [3:0] tcount_reg;
    logic [5:0] length_reg;
    logic       last_reg;

    // one result load per cycle
    logic       emit;
    logic [1:0] emit_kind;
    logic [7:0] emit_byte;
    logic [2:0] emit_index;
    logic       emit_end;
    logic [3:0] emit_tcount;
    logic [5:0] emit_length;
    logic       emit_last;

    // line store port
    logic                  ram_we;
    logic [STORE_BITS-1:0] ram_rdata;

    logic in_fire;
    logic slot_free;
    logic is_eol, is_erase, is_print;
    logic room, nonempty;
    logic [CW-1:0] ptr_inc;
    logic at_end;
    logic rd_sep;
    logic tok_full;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    // output register is free or being drained this cycle
    assign slot_free = !out_valid_reg || out_ready;

    assign is_eol   = (rx_byte == CH_CR) || (rx_byte == CH_LF);
    assign is_erase = (rx_byte == CH_DEL) || (rx_byte == CH_BS);
    assign is_print = (rx_byte >= CH_SP) && (rx_byte < CH_DEL);
    assign room     = (count_reg < CW'(LINE_CHARS));
    assign nonempty = (count_reg != '0);

    // walk pointer into the line, read data belongs to ptr_reg in S_DATA
    assign ptr_inc  = ptr_reg + 1'b1;
    assign at_end   = (ptr_inc >= count_reg);
    assign rd_sep   = is_sep(ram_rdata);
    assign tok_full = (tok_reg >= TW'(MAX_TOKENS));

    slet_ram #(
        .WIDTH (STORE_BITS),
        .DEPTH (LINE_CHARS)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (rx_byte[STORE_BITS-1:0]),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (is_eol || (is_erase && nonempty) || (is_print && room)))
                begin
                    state_next = S_ECHO;
                end
            end
            S_ECHO:
            begin
                if (slot_free)
                begin
                    priority if (op_reg == OP_EOL && step_reg == 2'd1)
                    begin
                        state_next = nonempty ? S_FETCH : S_SUM;
                    end
                    else if (op_reg == OP_CHAR || (op_reg == OP_ERASE && step_reg == 2'd2))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_ECHO;
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_DATA;
            end
            S_DATA:
            begin
                priority if (!have_cur_reg)
                begin
                    // scanning for a token start
                    priority if (rd_sep)
                    begin
                        state_next = at_end ? S_SUM : S_FETCH;
                    end
                    else if (tok_full)
                    begin
                        state_next = S_SUM;
                    end
                    else
                    begin
                        state_next = at_end ? S_LAST : S_FETCH;
                    end
                end
                else if (slot_free)
                begin
                    // pending character goes out, lookahead decides its end mark
                    priority if (rd_sep)
                    begin
                        state_next = at_end ? S_SUM : S_FETCH;
                    end
                    else
                    begin
                        state_next = at_end ? S_LAST : S_FETCH;
                    end
                end
                else
                begin
                    // pending character waits for the output register
                    state_next = S_DATA;
                end
            end
            S_LAST:
            begin
                if (slot_free)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        op_next       = op_reg;
        step_next     = step_reg;
        char_next     = char_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        tok_next      = tok_reg;
        have_cur_next = have_cur_reg;
        cur_next      = cur_reg;
        ram_we        = 1'b0;
        emit          = 1'b0;
        emit_kind     = KIND_ECHO;
        emit_byte     = '0;
        emit_index    = '0;
        emit_end      = 1'b0;
        emit_tcount   = '0;
        emit_length   = '0;
        emit_last     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    char_next = rx_byte;
                    step_next = 2'd0;
                    priority if (is_eol)
                    begin
                        op_next = OP_EOL;
                    end
                    else if (is_erase)
                    begin
                        op_next = OP_ERASE;
                        if (nonempty)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        op_next = OP_CHAR;
                        if (is_print && room)
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
            end
            S_ECHO:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    step_next = step_reg + 2'd1;
                    unique case (op_reg)
                        OP_CHAR:
                        begin
                            emit_byte = char_reg;
                            emit_last = 1'b1;
                        end
                        OP_ERASE:
                        begin
                            // backspace, space, backspace
                            emit_byte = (step_reg == 2'd1) ? CH_SP : CH_BS;
                            emit_last = (step_reg == 2'd2);
                        end
                        OP_EOL:
                        begin
                            emit_byte = (step_reg == 2'd0) ? CH_CR : CH_LF;
                            if (step_reg == 2'd1)
                            begin
                                ptr_next      = '0;
                                tok_next      = '0;
                                have_cur_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            emit_byte = char_reg;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                // store read of ptr_reg is in flight
            end
            S_DATA:
            begin
                if (!have_cur_reg)
                begin
                    if (rd_sep)
                    begin
                        ptr_next = ptr_inc;
                    end
                    else if (!tok_full)
                    begin
                        cur_next      = ram_rdata;
                        have_cur_next = 1'b1;
                        ptr_next      = ptr_inc;
                    end
                end
                else if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_kind  = KIND_TOKEN;
                    emit_byte  = {1'b0, cur_reg};
                    emit_index = 3'(tok_reg);
                    emit_end   = rd_sep;
                    ptr_next   = ptr_inc;
                    if (rd_sep)
                    begin
                        tok_next      = tok_reg + 1'b1;
                        have_cur_next = 1'b0;
                    end
                    else
                    begin
                        cur_next = ram_rdata;
                    end
                end
            end
            S_LAST:
            begin
                // final token runs to the end of the line
                if (slot_free)
                begin
                    emit          = 1'b1;
                    emit_kind     = KIND_TOKEN;
                    emit_byte     = {1'b0, cur_reg};
                    emit_index    = 3'(tok_reg);
                    emit_end      = 1'b1;
                    tok_next      = tok_reg + 1'b1;
                    have_cur_next = 1'b0;
                end
            end
            S_SUM:
            begin
                if (slot_free)
                begin
                    emit        = 1'b1;
                    emit_kind   = KIND_SUM;
                    emit_tcount = 4'(tok_reg);
                    emit_length = 6'(count_reg);
                    emit_last   = 1'b1;
                    count_next  = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            tok_reg       <= '0;
            have_cur_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            tok_reg      <= tok_next;
            have_cur_reg <= have_cur_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        step_reg <= step_next;
        char_reg <= char_next;
        ptr_reg  <= ptr_next;
        cur_reg  <= cur_next;
        if (emit)
        begin
            kind_reg   <= emit_kind;
            byte_reg   <= emit_byte;
            index_reg  <= emit_index;
            end_reg    <= emit_end;
            tcount_reg <= emit_tcount;
            length_reg <= emit_length;
            last_reg   <= emit_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign byte_value  = byte_reg;
    assign token_index = index_reg;
    assign token_end   = end_reg;
    assign token_count = tcount_reg;
    assign line_length = length_reg;
    assign last        = last_reg;

    // line never holds more than its capacity
    `SLET_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(LINE_CHARS), "line count over capacity")
    // token counter stops at the token limit
    `SLET_ASSERT_ALWAYS(a_tok_bound, tok_reg <= TW'(MAX_TOKENS), "token count over limit")
    // a stored printable byte grows the line by exactly one
    `SLET_ASSERT_NEXT(a_store_grow, in_fire && is_print && room, count_reg == $past(count_reg) + 1'b1, "printable byte not stored")
    // no result is loaded while the block waits for a new byte
    `SLET_ASSERT_SAME(a_idle_quiet, state_reg == S_IDLE, !emit, "result produced while idle")
    // a summary always closes the group of results of its byte
    `SLET_ASSERT_SAME(a_sum_last, out_valid && kind == KIND_SUM, last, "summary without last mark")

endmodule

// ----- hw/rtl/slet_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module slet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- tb/sv/serial_line_editor_tokenizer_core_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for serial_line_editor_tokenizer_core: echo, erase and line-end tokens
// needs slet_pkg and the core rtl; random bytes come from the simulator seed
module serial_line_editor_tokenizer_core_tb;
    import slet_pkg::*;

    // one output transfer, fields in port order
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic [2:0] tok_idx;
        logic       tok_end;
        logic [3:0] tok_cnt;
        logic [5:0] length;
        logic       last;
    } out_word_t;

    // line model plus the queue of outputs still owed by the core
    class line_editor_scoreboard;
        logic [STORE_BITS-1:0] chars [LINE_CHARS_DEF];
        int unsigned           n_chars;
        out_word_t             pending_outputs[$];
        int                    errors;

        function new();
            n_chars = 0;
            errors  = 0;
        endfunction

        function bit is_blank(logic [STORE_BITS-1:0] c);
            return c == CH_SP[STORE_BITS-1:0] || c == CH_TAB[STORE_BITS-1:0];
        endfunction

        function void owe(logic [1:0] k, logic [7:0] v, logic [2:0] ti, logic te,
                          logic [3:0] tc, logic [5:0] len, logic lst);
            out_word_t w;
            w = '{kind: k, value: v, tok_idx: ti, tok_end: te, tok_cnt: tc,
                  length: len, last: lst};
            pending_outputs = {pending_outputs, w};
        endfunction

        // what one accepted byte makes the core emit
        function void note_rx_byte(logic [7:0] b);
            int unsigned i;
            int unsigned ntok;
            bit          tail;
            if (b == CH_CR || b == CH_LF)
            begin
                owe(KIND_ECHO, CH_CR, 3'd0, 1'b0, 4'd0, 6'd0, 1'b0);
                owe(KIND_ECHO, CH_LF, 3'd0, 1'b0, 4'd0, 6'd0, 1'b0);
                i    = 0;
                ntok = 0;
                while (i < n_chars)
                begin
                    while (i < n_chars && is_blank(chars[i]))
                        i++;
                    if (i >= n_chars || ntok >= MAX_TOKENS_DEF)
                        break;
                    while (i < n_chars && !is_blank(chars[i]))
                    begin
                        tail = (i + 1 >= n_chars) || is_blank(chars[i + 1]);
                        owe(KIND_TOKEN, {1'b0, chars[i]}, ntok[2:0], tail, 4'd0, 6'd0, 1'b0);
                        i++;
                    end
                    ntok++;
                end
                owe(KIND_SUM, 8'd0, 3'd0, 1'b0, ntok[3:0], n_chars[5:0], 1'b1);
                n_chars = 0;
            end
            else if ((b == CH_DEL || b == CH_BS) && n_chars > 0)
            begin
                n_chars--;
                owe(KIND_ECHO, CH_BS, 3'd0, 1'b0, 4'd0, 6'd0, 1'b0);
                owe(KIND_ECHO, CH_SP, 3'd0, 1'b0, 4'd0, 6'd0, 1'b0);
                owe(KIND_ECHO, CH_BS, 3'd0, 1'b0, 4'd0, 6'd0, 1'b1);
            end
            else if (b >= CH_SP && b < CH_DEL && n_chars < LINE_CHARS_DEF)
            begin
                chars[n_chars] = b[STORE_BITS-1:0];
                n_chars++;
                owe(KIND_ECHO, b, 3'd0, 1'b0, 4'd0, 6'd0, 1'b1);
            end
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check_output(out_word_t got);
            out_word_t want;
            if (pending_outputs.size() == 0)
            begin
                report($sformatf("unexpected output kind %0d byte %02h", got.kind, got.value));
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (got !== want)
                    report($sformatf({"got kind %0d byte %02h idx %0d end %0d cnt %0d len %0d ",
                                      "last %0d, want kind %0d byte %02h idx %0d end %0d ",
                                      "cnt %0d len %0d last %0d"},
                                     got.kind, got.value, got.tok_idx, got.tok_end,
                                     got.tok_cnt, got.length, got.last,
                                     want.kind, want.value, want.tok_idx, want.tok_end,
                                     want.tok_cnt, want.length, want.last));
            end
        endtask
    endclass

    // clock and block inputs, all known from time zero
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] rx_byte   = 8'd0;
    logic       out_ready = 1'b0;

    logic       in_ready;
    logic       out_valid;
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [2:0] token_index;
    logic       token_end;
    logic [3:0] token_count;
    logic [5:0] line_length;
    logic       last;

    line_editor_scoreboard sb = new();

    // quiet stretches with no idling for either side
    int send_quiet = 0;
    int recv_quiet = 0;

    serial_line_editor_tokenizer_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .byte_value (byte_value),
        .token_index(token_index),
        .token_end  (token_end),
        .token_count(token_count),
        .line_length(line_length),
        .last       (last)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // random idle gap before the next transfer, with occasional quiet runs
    function automatic int draw_idle(inout int quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            quiet = int'($urandom_range(10, 30));
        return int'($urandom_range(0, 13));
    endfunction

    // a byte the core should drop: stray control codes and the upper half
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        case ($urandom_range(0, 2))
            0:       b = 8'($urandom_range(128, 255));
            1:       b = 8'($urandom_range(0, 7));
            default: b = 8'($urandom_range(11, 31));
        endcase
        if (b == CH_CR)
            b = 8'd14;
        return b;
    endfunction

    // input transfers feed the predictor; values seen are the pre-edge ones
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_rx_byte(rx_byte);
    end

    // output transfers are checked against the oldest owed output
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_output({kind, byte_value, token_index, token_end, token_count,
                             line_length, last});
    end

    // offer one byte, valid held until the transfer; valid only drops when a gap follows
    task send_byte(logic [7:0] b);
        int idle;
        idle = draw_idle(send_quiet);
        if (idle > 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // receiver: random stall per transfer, one long hold-off to back the core up
    initial
    begin
        int stall;
        int taken;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            if (taken == 40)
                stall = 400;
            else
                stall = draw_idle(recv_quiet);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
        end
    end

    // stimulus and end of run
    initial
    begin
        logic [7:0] seq[$];
        int         line_no;
        int         counted;
        int         shape;
        int         n;
        int         len;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty line end, erase on empty line, ignored bytes, extremes,
        // tab as separator, erase, line end by LF and by CR with a trailing blank
        seq = '{CH_CR, CH_BS, CH_DEL, 8'h00, 8'hFF, 8'h80, 8'h1B,
                CH_SP, 8'd126, 8'h41, CH_TAB, 8'h62, CH_BS, 8'h63, CH_SP, CH_SP, 8'h7A, CH_LF,
                8'h71, CH_SP, CH_CR};
        foreach (seq[k])
            send_byte(seq[k]);

        // random lines: mostly well formed, some noise, overflowing and token-heavy lines
        line_no = 0;
        counted = seq.size();
        while (counted < 210)
        begin
            seq.delete();
            shape = (line_no < 4) ? line_no : int'($urandom_range(0, 9));
            case (shape)
                0:
                begin
                    n = int'($urandom_range(1, 3));
                    repeat (n) seq = {seq, noise_byte()};
                end
                1:
                begin
                    // more than a full line, then an erase on some lines, and a line end
                    n = int'($urandom_range(LINE_CHARS_DEF + 2, LINE_CHARS_DEF + 12));
                    repeat (n) seq = {seq, 8'($urandom_range(32, 126))};
                    if ($urandom_range(0, 1))
                        seq = {seq, CH_DEL};
                    seq = {seq, CH_LF};
                end
                2:
                begin
                    // more tokens than are counted
                    n = int'($urandom_range(MAX_TOKENS_DEF + 1, MAX_TOKENS_DEF + 6));
                    repeat (n)
                    begin
                        len = int'($urandom_range(1, 2));
                        repeat (len) seq = {seq, 8'($urandom_range(33, 126))};
                        seq = {seq, ($urandom_range(0, 3) == 0) ? CH_TAB : CH_SP};
                        seq = {seq, CH_SP};
                    end
                    seq = {seq, CH_CR};
                end
                default:
                begin
                    if ($urandom_range(0, 3) == 0)
                        seq = {seq, $urandom_range(0, 1) ? CH_BS : CH_DEL};
                    if ($urandom_range(0, 2) == 0)
                        seq = {seq, CH_SP};
                    n = int'($urandom_range(0, 5));
                    repeat (n)
                    begin
                        len = int'($urandom_range(1, 6));
                        repeat (len)
                        begin
                            seq = {seq, 8'($urandom_range(33, 126))};
                            if ($urandom_range(0, 9) == 0)
                                seq = {seq, $urandom_range(0, 1) ? CH_BS : CH_DEL};
                            if ($urandom_range(0, 14) == 0)
                                seq = {seq, noise_byte()};
                        end
                        seq = {seq, CH_SP};
                        if ($urandom_range(0, 3) == 0)
                            seq = {seq, CH_TAB};
                        if ($urandom_range(0, 3) == 0)
                            seq = {seq, CH_SP};
                    end
                    seq = {seq, $urandom_range(0, 1) ? CH_CR : CH_LF};
                end
            endcase
            foreach (seq[k])
            begin
                // every byte offered counts toward the item budget, dropped ones too
                if (counted < 210)
                begin
                    send_byte(seq[k]);
                    counted++;
                end
            end
            line_no++;
        end
        in_valid <= 1'b0;

        // let the predictor see the last input transfer, then drain
        @(posedge clk);
        while (sb.pending_outputs.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // run limit, far beyond the slowest legal run
    initial
    begin
        #9600000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/slet_pkg.sv
hw/rtl/slet_ram.sv
hw/rtl/serial_line_editor_tokenizer_core.sv
tb/sv/serial_line_editor_tokenizer_core_tb.sv
